@@ hw/rtl/circular_list_position_engine_defines.svh @@
// assertion macros used by the request sequencer of the position engine rtl
`ifndef CIRCULAR_LIST_POSITION_ENGINE_DEFINES_SVH
`define CIRCULAR_LIST_POSITION_ENGINE_DEFINES_SVH

// condition holds at every edge out of reset
`define CLPE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CLPE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CLPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/clpe_pkg.sv @@
// types, codes and widths of the circular list position engine
package clpe_pkg;

    localparam int CLPE_CAPACITY = 32;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int TOTAL_W = 6;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd5;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic        [MODE_W-1:0] mode;
        logic        [POS_W-1:0]  position;
        logic signed [VAL_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic        [ST_W-1:0]    status;
        logic        [TOTAL_W-1:0] entry_total;
        logic signed [VAL_W-1:0]   first_value;
        logic signed [VAL_W-1:0]   last_value;
    } res_t;

endpackage

@@ hw/rtl/clpe_chan_if.sv @@
// valid/ready channel carrying one word of type T
interface clpe_chan_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

@@ hw/rtl/circular_list_position_engine.sv @@
// Circular list position engine: a bounded circular singly linked list of signed 32-bit values
// held in a value memory and a link memory, one request word in and one result word out per
// request. Requests that only report a status go straight to the result. Inserts at either
// end and deletes at the front need no walk; deletes at the back and at a later position, and
// inserts at an inner position, walk the list from the head one link per cycle through the
// single read port of the link memory. The next request is taken while a result still waits in
// the output register. Free slots are handed out from a fill counter and then from a free chain
// kept in the link memory, so there is no clearing pass after reset and the block is ready as
// soon as reset is released.
module circular_list_position_engine
    import clpe_pkg::*;
#(
    parameter int CAPACITY = CLPE_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    clpe_chan_if.sink   req,
    clpe_chan_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    clpe_chan_if #(.T(res_t)) res_ch ();

    logic                    link_we;
    logic [AW-1:0]           link_waddr;
    logic [AW-1:0]           link_wdata;
    logic [AW-1:0]           link_raddr;
    logic [AW-1:0]           link_rdata;
    logic                    val_we;
    logic [AW-1:0]           val_waddr;
    logic signed [VAL_W-1:0] val_wdata;
    logic [AW-1:0]           val_raddr;
    logic signed [VAL_W-1:0] val_rdata;

    logic rsp_valid_reg, rsp_valid_next;
    res_t rsp_data_reg, rsp_data_next;

    clpe_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .res        (res_ch),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .val_we     (val_we),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .val_raddr  (val_raddr),
        .val_rdata  (val_rdata)
    );

    clpe_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (AW)
    ) u_link_mem (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    clpe_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (VAL_W)
    ) u_val_mem (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // output word register
    assign res_ch.ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (res_ch.ready)
        begin
            rsp_valid_next = res_ch.valid;
            if (res_ch.valid)
            begin
                rsp_data_next = res_ch.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

@@ hw/rtl/clpe_mem.sv @@
// single write port, single read port synchronous memory with write forwarding
module clpe_mem
    import clpe_pkg::*;
#(
    parameter int DEPTH = CLPE_CAPACITY,
    parameter int WIDTH = VAL_W,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/clpe_ctrl.sv @@
// request sequencer: decode, link walk and read-modify-write of the list stores
`include "circular_list_position_engine_defines.svh"

module clpe_ctrl
    import clpe_pkg::*;
#(
    parameter int CAPACITY = CLPE_CAPACITY,
    localparam int AW = $clog2(CAPACITY)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    clpe_chan_if.sink               req,
    clpe_chan_if.source             res,
    output logic                    link_we,
    output logic [AW-1:0]           link_waddr,
    output logic [AW-1:0]           link_wdata,
    output logic [AW-1:0]           link_raddr,
    input  logic [AW-1:0]           link_rdata,
    output logic                    val_we,
    output logic [AW-1:0]           val_waddr,
    output logic signed [VAL_W-1:0] val_wdata,
    output logic [AW-1:0]           val_raddr,
    input  logic signed [VAL_W-1:0] val_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_ALLOC  = 4'd1;
    localparam logic [3:0] S_WSTART = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_PREV   = 4'd4;
    localparam logic [3:0] S_INS1   = 4'd5;
    localparam logic [3:0] S_INS2   = 4'd6;
    localparam logic [3:0] S_INSM   = 4'd7;
    localparam logic [3:0] S_DF1    = 4'd8;
    localparam logic [3:0] S_DF2    = 4'd9;
    localparam logic [3:0] S_DVIC   = 4'd10;
    localparam logic [3:0] S_DFREE  = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    localparam logic [1:0] W_FRONT = 2'd0;
    localparam logic [1:0] W_BACK  = 2'd1;
    localparam logic [1:0] W_MID   = 2'd2;

    logic [3:0]              state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           fresh_reg, fresh_next;
    logic [AW-1:0]           head_reg, head_next;
    logic [AW-1:0]           tail_reg, tail_next;
    logic [AW-1:0]           free_top_reg, free_top_next;
    logic                    is_ins_reg, is_ins_next;
    logic [1:0]              where_reg, where_next;
    logic                    tail_moved_reg, tail_moved_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic [CW-1:0]           steps_reg, steps_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           slot_reg, slot_next;
    logic [AW-1:0]           victim_reg, victim_next;
    logic [ST_W-1:0]         status_reg, status_next;
    logic signed [VAL_W-1:0] head_val_reg, head_val_next;
    logic signed [VAL_W-1:0] tail_val_reg, tail_val_next;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          is_empty;
    logic          is_full;

    assign pos_x    = XW'(req.data.position);
    assign cnt_x    = XW'(count_reg);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CAP_C);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        logic [1:0] where_d;

        where_d         = W_MID;
        state_next      = state_reg;
        count_next      = count_reg;
        fresh_next      = fresh_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_top_next   = free_top_reg;
        is_ins_next     = is_ins_reg;
        where_next      = where_reg;
        tail_moved_next = tail_moved_reg;
        value_next      = value_reg;
        steps_next      = steps_reg;
        cur_next        = cur_reg;
        slot_next       = slot_reg;
        victim_next     = victim_reg;
        status_next     = status_reg;
        head_val_next   = head_val_reg;
        tail_val_next   = tail_val_reg;

        link_we    = 1'b0;
        link_waddr = slot_reg;
        link_wdata = slot_reg;
        link_raddr = free_top_reg;
        val_we     = 1'b0;
        val_waddr  = slot_reg;
        val_wdata  = value_reg;
        val_raddr  = cur_reg;
        res.valid  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    value_next      = req.data.value;
                    cur_next        = head_reg;
                    status_next     = ST_OK;
                    tail_moved_next = 1'b0;
                    unique case (req.data.mode) inside
                        MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT:
                        begin
                            if ((req.data.mode == MODE_INS_AT) && (pos_x > cnt_x))
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else if (is_full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                if (is_empty || (req.data.mode == MODE_INS_FRONT) ||
                                    ((req.data.mode == MODE_INS_AT) && (pos_x == '0)))
                                begin
                                    where_d = W_FRONT;
                                end
                                else if ((req.data.mode == MODE_INS_BACK) ||
                                         (pos_x == cnt_x))
                                begin
                                    where_d = W_BACK;
                                end
                                else
                                begin
                                    where_d = W_MID;
                                end
                                is_ins_next = 1'b1;
                                where_next  = where_d;
                                steps_next  = CW'(pos_x - XW'(1));
                                if (fresh_reg != CAP_C)
                                begin
                                    slot_next  = fresh_reg[AW-1:0];
                                    fresh_next = fresh_reg + CW'(1);
                                    state_next = (where_d == W_MID) ? S_WSTART : S_INS1;
                                end
                                else
                                begin
                                    state_next = S_ALLOC;
                                end
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT:
                        begin
                            is_ins_next = 1'b0;
                            if (is_empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else if ((req.data.mode == MODE_DEL_AT) && (pos_x >= cnt_x))
                            begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                victim_next = head_reg;
                                where_next  = W_FRONT;
                                state_next  = S_DFREE;
                            end
                            else if ((req.data.mode == MODE_DEL_FRONT) ||
                                     ((req.data.mode == MODE_DEL_AT) && (pos_x == '0)))
                            begin
                                where_next = W_FRONT;
                                state_next = S_DF1;
                            end
                            else
                            begin
                                where_next = W_MID;
                                if (req.data.mode == MODE_DEL_BACK)
                                begin
                                    steps_next = count_reg - CW'(2);
                                end
                                else
                                begin
                                    steps_next = CW'(pos_x - XW'(1));
                                end
                                state_next = S_WSTART;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                slot_next     = free_top_reg;
                free_top_next = link_rdata;
                state_next    = (where_reg == W_MID) ? S_WSTART : S_INS1;
            end
            S_WSTART:
            begin
                link_raddr = cur_reg;
                state_next = (steps_reg == '0) ? S_PREV : S_WALK;
            end
            S_WALK:
            begin
                link_raddr = link_rdata;
                cur_next   = link_rdata;
                steps_next = steps_reg - CW'(1);
                if (steps_reg == CW'(1))
                begin
                    state_next = S_PREV;
                end
            end
            S_PREV:
            begin
                if (is_ins_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = slot_reg;
                    link_wdata = link_rdata;
                    val_we     = 1'b1;
                    state_next = S_INSM;
                end
                else
                begin
                    link_raddr      = link_rdata;
                    victim_next     = link_rdata;
                    tail_moved_next = (link_rdata == tail_reg);
                    state_next      = S_DVIC;
                end
            end
            S_INSM:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = slot_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_INS1:
            begin
                link_we    = 1'b1;
                link_waddr = slot_reg;
                link_wdata = is_empty ? slot_reg : head_reg;
                val_we     = 1'b1;
                if (is_empty)
                begin
                    head_next     = slot_reg;
                    tail_next     = slot_reg;
                    head_val_next = value_reg;
                    tail_val_next = value_reg;
                    count_next    = count_reg + CW'(1);
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_INS2;
                end
            end
            S_INS2:
            begin
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = slot_reg;
                if (where_reg == W_FRONT)
                begin
                    head_next     = slot_reg;
                    head_val_next = value_reg;
                end
                else
                begin
                    tail_next     = slot_reg;
                    tail_val_next = value_reg;
                end
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_DF1:
            begin
                link_raddr  = head_reg;
                victim_next = head_reg;
                state_next  = S_DF2;
            end
            S_DF2:
            begin
                head_next  = link_rdata;
                link_we    = 1'b1;
                link_waddr = tail_reg;
                link_wdata = link_rdata;
                val_raddr  = link_rdata;
                state_next = S_DFREE;
            end
            S_DVIC:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = link_rdata;
                if (tail_moved_reg)
                begin
                    tail_next = cur_reg;
                end
                state_next = S_DFREE;
            end
            S_DFREE:
            begin
                link_we       = 1'b1;
                link_waddr    = victim_reg;
                link_wdata    = free_top_reg;
                free_top_next = victim_reg;
                count_next    = count_reg - CW'(1);
                if (where_reg == W_FRONT)
                begin
                    head_val_next = val_rdata;
                end
                else if (tail_moved_reg)
                begin
                    tail_val_next = val_rdata;
                end
                if (count_reg == CW'(1))
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res.valid = 1'b1;
                if (res.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.data.status      = status_reg;
        res.data.entry_total = TOTAL_W'(count_reg);
        res.data.first_value = (count_reg == '0) ? '0 : head_val_reg;
        res.data.last_value  = (count_reg == '0) ? '0 : tail_val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            fresh_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            free_top_reg   <= '0;
            is_ins_reg     <= 1'b0;
            where_reg      <= W_FRONT;
            tail_moved_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            fresh_reg      <= fresh_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_top_reg   <= free_top_next;
            is_ins_reg     <= is_ins_next;
            where_reg      <= where_next;
            tail_moved_reg <= tail_moved_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        steps_reg    <= steps_next;
        cur_reg      <= cur_next;
        slot_reg     <= slot_next;
        victim_reg   <= victim_next;
        status_reg   <= status_next;
        head_val_reg <= head_val_next;
        tail_val_reg <= tail_val_next;
    end

    `CLPE_ASSERT_ALWAYS(a_slots_from_fresh, (count_reg <= fresh_reg) && (fresh_reg <= CAP_C), "entry count exceeds slots ever handed out")
    `CLPE_ASSERT_IMPLY(a_walk_steps_left, state_reg == S_WALK, steps_reg != '0, "link walk running with no steps left")
    `CLPE_ASSERT_NEXT(a_accept_leaves_idle, req.valid && req.ready, state_reg != S_IDLE, "accepted word did not start a request")
    `CLPE_ASSERT_NEXT(a_count_only_on_update, (state_reg != S_INS1) && (state_reg != S_INS2) && (state_reg != S_INSM) && (state_reg != S_DFREE), $stable(count_reg), "entry count changed outside an update state")

endmodule
